// ===== sv/bhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// bhpq_pkg
// shared codes and control types of the binary heap priority queue
// ----------------------------------------------------------------------------
package bhpq_pkg;

  // operation codes on in_op
  localparam logic OP_PUT = 1'b0;
  localparam logic OP_POP = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // completion info from the sequencer
  typedef struct packed {
    logic    done;
    status_t status;
  } res_t;

endpackage

// ===== sv/bhpq_mem.sv =====
// ----------------------------------------------------------------------------
// bhpq_mem
// heap entry store: one write port, two registered read ports
// ----------------------------------------------------------------------------
module bhpq_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a_r <= mem_r[raddr_a];
    rdata_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ===== sv/bhpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bhpq_ctrl
// sift sequencer: walks the heap one level per cycle through the store
// ----------------------------------------------------------------------------
module bhpq_ctrl #(
  parameter int DEPTH      = 1024,
  parameter int KEY_WIDTH  = 32,
  parameter int DATA_WIDTH = 16,
  localparam int AW        = $clog2(DEPTH),
  localparam int CNT_W     = $clog2(DEPTH + 1),
  localparam int EW        = KEY_WIDTH + DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  op,
  input  logic [KEY_WIDTH-1:0]  entry_key,
  input  logic [DATA_WIDTH-1:0] entry_data,
  input  logic                  order_mode,
  output logic                  busy,
  // store access
  output logic                  mem_we,
  output logic [AW-1:0]         mem_waddr,
  output logic [EW-1:0]         mem_wdata,
  output logic [AW-1:0]         mem_raddr_a,
  output logic [AW-1:0]         mem_raddr_b,
  input  logic [EW-1:0]         mem_rdata_a,
  input  logic [EW-1:0]         mem_rdata_b,
  // completion
  output bhpq_pkg::res_t        res,
  output logic [KEY_WIDTH-1:0]  res_popped_key,
  output logic [DATA_WIDTH-1:0] res_popped_data,
  output logic [KEY_WIDTH-1:0]  res_top_key,
  output logic [DATA_WIDTH-1:0] res_top_data,
  output logic [CNT_W-1:0]      res_count
);

  localparam int CW = AW + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_LAST,
    S_DOWN,
    S_PLACE
  } state_t;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  op_r, op_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic [EW-1:0]         ent_r, ent_nxt;
  logic [EW-1:0]         pop_r, pop_nxt;
  logic [EW-1:0]         root_r, root_nxt;

  logic [AW-1:0]         up_idx;
  logic [AW-1:0]         up_up_idx;
  logic [CW-1:0]         lch, rch, n_ext, nl;
  logic [KEY_WIDTH-1:0]  a_key, b_key, ent_key, best_key;
  logic [EW-1:0]         best_ent;
  logic [AW-1:0]         best_idx;
  logic                  take_r;
  logic                  done_pop;
  logic [EW-1:0]         popped;

  function automatic logic key_before(input logic mode, input logic [KEY_WIDTH-1:0] a,
                                      input logic [KEY_WIDTH-1:0] b);
    return mode ? (a > b) : (a < b);
  endfunction

  assign up_idx    = (pos_r - AW'(1)) >> 1;
  assign up_up_idx = (up_idx - AW'(1)) >> 1;
  assign lch       = {pos_r, 1'b1};
  assign rch       = lch + CW'(1);
  assign n_ext     = CW'(cnt_r);
  assign a_key     = mem_rdata_a[DATA_WIDTH +: KEY_WIDTH];
  assign b_key     = mem_rdata_b[DATA_WIDTH +: KEY_WIDTH];
  assign ent_key   = ent_r[DATA_WIDTH +: KEY_WIDTH];

  // right child wins when present, unless the left one is strictly before it
  assign take_r   = (rch < n_ext) && !key_before(order_mode, a_key, b_key);
  assign best_ent = take_r ? mem_rdata_b : mem_rdata_a;
  assign best_key = best_ent[DATA_WIDTH +: KEY_WIDTH];
  assign best_idx = take_r ? AW'(rch) : AW'(lch);
  assign nl       = {best_idx, 1'b1};

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    op_nxt      = op_r;
    pos_nxt     = pos_r;
    ent_nxt     = ent_r;
    pop_nxt     = pop_r;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_raddr_a = '0;
    mem_raddr_b = '0;
    res.done    = 1'b0;
    res.status  = bhpq_pkg::ST_OK;
    done_pop    = 1'b0;
    popped      = pop_r;
    case (state_r)
      S_IDLE: begin
        popped = root_r;
        if (start) begin
          op_nxt = op;
          if (op == bhpq_pkg::OP_PUT) begin
            if (cnt_r == CNT_W'(DEPTH)) begin
              res.done   = 1'b1;
              res.status = bhpq_pkg::ST_FULL;
            end else if (cnt_r == '0) begin
              mem_we    = 1'b1;
              mem_wdata = {entry_key, entry_data};
              cnt_nxt   = CNT_W'(1);
              res.done  = 1'b1;
            end else begin
              ent_nxt     = {entry_key, entry_data};
              pos_nxt     = AW'(cnt_r);
              mem_raddr_a = (AW'(cnt_r) - AW'(1)) >> 1;
              state_nxt   = S_UP;
            end
          end else begin
            if (cnt_r == '0) begin
              res.done   = 1'b1;
              res.status = bhpq_pkg::ST_EMPTY;
            end else begin
              pop_nxt = root_r;
              cnt_nxt = cnt_r - CNT_W'(1);
              pos_nxt = '0;
              if (cnt_r == CNT_W'(1)) begin
                res.done = 1'b1;
                done_pop = 1'b1;
              end else begin
                mem_raddr_a = AW'(cnt_r - CNT_W'(1));
                state_nxt   = S_LAST;
              end
            end
          end
        end
      end
      S_UP: begin
        // parent sits in read port a
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        if (key_before(order_mode, ent_key, a_key)) begin
          mem_wdata = mem_rdata_a;
          pos_nxt   = up_idx;
          if (up_idx == '0) begin
            state_nxt = S_PLACE;
          end else begin
            mem_raddr_a = up_up_idx;
          end
        end else begin
          mem_wdata = ent_r;
          cnt_nxt   = cnt_r + CNT_W'(1);
          res.done  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_LAST: begin
        // last entry arrives, it becomes the moving entry
        ent_nxt = mem_rdata_a;
        if (lch >= n_ext) begin
          mem_we    = 1'b1;
          mem_waddr = pos_r;
          mem_wdata = mem_rdata_a;
          res.done  = 1'b1;
          done_pop  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          mem_raddr_a = AW'(lch);
          mem_raddr_b = AW'(rch);
          state_nxt   = S_DOWN;
        end
      end
      S_DOWN: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        if (key_before(order_mode, ent_key, best_key)) begin
          mem_wdata = ent_r;
          res.done  = 1'b1;
          done_pop  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          mem_wdata = best_ent;
          pos_nxt   = best_idx;
          if (nl >= n_ext) begin
            state_nxt = S_PLACE;
          end else begin
            mem_raddr_a = AW'(nl);
            mem_raddr_b = AW'(nl + CW'(1));
          end
        end
      end
      S_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = ent_r;
        res.done  = 1'b1;
        if (op_r == bhpq_pkg::OP_PUT) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end else begin
          done_pop = 1'b1;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // root copy follows every write to the root slot
  assign root_nxt = (mem_we && mem_waddr == '0) ? mem_wdata : root_r;

  assign busy            = (state_r != S_IDLE);
  assign res_popped_key  = done_pop ? popped[DATA_WIDTH +: KEY_WIDTH] : '0;
  assign res_popped_data = done_pop ? popped[DATA_WIDTH-1:0] : '0;
  assign res_count       = cnt_nxt;
  assign res_top_key     = (cnt_nxt != '0) ? root_nxt[DATA_WIDTH +: KEY_WIDTH] : '0;
  assign res_top_data    = (cnt_nxt != '0) ? root_nxt[DATA_WIDTH-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      op_r    <= bhpq_pkg::OP_PUT;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      op_r    <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    ent_r  <= ent_nxt;
    pop_r  <= pop_nxt;
    root_r <= root_nxt;
  end

endmodule

// ===== sv/binary_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// binary_heap_priority_queue
// binary heap priority queue of key/data entries held in one dual-read ram
// ----------------------------------------------------------------------------
// usage
//   command channel: raise start with in_op, in_entry_key, in_entry_data;
//   the command transfers at a rising edge with start high and busy low.
//   in_op put inserts the entry, pop removes the top entry.
//   result channel: out_valid is high for exactly one cycle per command and
//   carries status, the popped entry, the new top, the count and an empty
//   flag; the receiver always takes it, there is no back-pressure.
//   cfg channel: cfg_order_mode picks min-heap (0) or max-heap (1); it
//   transfers on cfg_valid and cfg_ready, ready only while idle with no
//   command offered, so the order never changes under a running sift.
// timing
//   refused commands, puts into an empty heap and pops of the only entry
//   end in S_IDLE, a pop leaving one entry in S_LAST. otherwise a put runs
//   S_UP per level moved, ending in S_UP or S_PLACE; a pop runs S_LAST and
//   S_DOWN per level moved, ending in S_DOWN or S_PLACE (log2(DEPTH) levels
//   at most). a result is registered and shows in the cycle after the final
//   state, as busy drops, so the next command can transfer while it shows.
// reset
//   rst_n clears the count, the order mode and the sequencer; the store is
//   not cleared, only entries below the count are ever used.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue #(
  parameter int DEPTH      = 1024,
  parameter int KEY_WIDTH  = 32,
  parameter int DATA_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // command channel
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_op,
  input  logic [KEY_WIDTH-1:0]           in_entry_key,
  input  logic [DATA_WIDTH-1:0]          in_entry_data,
  // result channel
  output logic                           out_valid,
  output logic [1:0]                     out_status,
  output logic [KEY_WIDTH-1:0]           out_popped_key,
  output logic [DATA_WIDTH-1:0]          out_popped_data,
  output logic [KEY_WIDTH-1:0]           out_top_key,
  output logic [DATA_WIDTH-1:0]          out_top_data,
  output logic [$clog2(DEPTH + 1)-1:0]   out_entry_count,
  output logic                           out_heap_empty,
  // configuration channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_order_mode
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int EW    = KEY_WIDTH + DATA_WIDTH;

  // order register
  logic order_r;

  // store wires
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr_a;
  logic [AW-1:0] mem_raddr_b;
  logic [EW-1:0] mem_rdata_a;
  logic [EW-1:0] mem_rdata_b;

  // sequencer completion
  bhpq_pkg::res_t        res;
  logic [KEY_WIDTH-1:0]  res_popped_key;
  logic [DATA_WIDTH-1:0] res_popped_data;
  logic [KEY_WIDTH-1:0]  res_top_key;
  logic [DATA_WIDTH-1:0] res_top_data;
  logic [CNT_W-1:0]      res_count;
  logic                  accept;

  // result register
  logic                  out_valid_r;
  logic [1:0]            status_r;
  logic [KEY_WIDTH-1:0]  popped_key_r;
  logic [DATA_WIDTH-1:0] popped_data_r;
  logic [KEY_WIDTH-1:0]  top_key_r;
  logic [DATA_WIDTH-1:0] top_data_r;
  logic [CNT_W-1:0]      count_r;
  logic                  empty_r;

  // a command transfers only while the sequencer sits idle
  assign accept    = start && !busy;
  // the register is writable only while idle and no command is offered
  assign cfg_ready = !busy && !start;

  bhpq_mem #(
    .DEPTH (DEPTH),
    .WIDTH (EW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  bhpq_ctrl #(
    .DEPTH      (DEPTH),
    .KEY_WIDTH  (KEY_WIDTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (accept),
    .op              (in_op),
    .entry_key       (in_entry_key),
    .entry_data      (in_entry_data),
    .order_mode      (order_r),
    .busy            (busy),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_raddr_a     (mem_raddr_a),
    .mem_raddr_b     (mem_raddr_b),
    .mem_rdata_a     (mem_rdata_a),
    .mem_rdata_b     (mem_rdata_b),
    .res             (res),
    .res_popped_key  (res_popped_key),
    .res_popped_data (res_popped_data),
    .res_top_key     (res_top_key),
    .res_top_data    (res_top_data),
    .res_count       (res_count)
  );

  // control: strobe and order mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      order_r     <= 1'b0;
    end else begin
      out_valid_r <= res.done;
      if (cfg_valid && cfg_ready) begin
        order_r <= cfg_order_mode;
      end
    end
  end

  // payload captured on completion, shown with the strobe and held until the next completion
  always_ff @(posedge clk) begin
    if (res.done) begin
      status_r      <= res.status;
      popped_key_r  <= res_popped_key;
      popped_data_r <= res_popped_data;
      top_key_r     <= res_top_key;
      top_data_r    <= res_top_data;
      count_r       <= res_count;
      empty_r       <= (res_count == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_popped_key  = popped_key_r;
  assign out_popped_data = popped_data_r;
  assign out_top_key     = top_key_r;
  assign out_top_data    = top_data_r;
  assign out_entry_count = count_r;
  assign out_heap_empty  = empty_r;

endmodule

// ===== sv/bhpq_check.sv =====
// ----------------------------------------------------------------------------
// bhpq_check
// port-level checks on the result channel of the priority queue
// ----------------------------------------------------------------------------
module bhpq_check #(
  parameter int DEPTH      = 1024,
  parameter int KEY_WIDTH  = 32,
  parameter int DATA_WIDTH = 16
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic [1:0]                   out_status,
  input logic [KEY_WIDTH-1:0]         out_popped_key,
  input logic [DATA_WIDTH-1:0]        out_popped_data,
  input logic [KEY_WIDTH-1:0]         out_top_key,
  input logic [DATA_WIDTH-1:0]        out_top_data,
  input logic [$clog2(DEPTH + 1)-1:0] out_entry_count,
  input logic                         out_heap_empty
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  // empty flag agrees with the count
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_heap_empty == (out_entry_count == '0)))
    else $error("empty flag disagrees with entry count");

  // an empty heap shows a zero top
  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_heap_empty) |-> (out_top_key == '0 && out_top_data == '0))
    else $error("top entry not zero on empty heap");

  // refused commands carry no popped entry
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != bhpq_pkg::ST_OK) |->
      (out_popped_key == '0 && out_popped_data == '0))
    else $error("popped entry on refused command");

  // full refusal only at capacity, empty refusal only at zero
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == bhpq_pkg::ST_FULL) |->
      (out_entry_count == CNT_W'(DEPTH)))
    else $error("full status below capacity");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == bhpq_pkg::ST_EMPTY) |-> (out_entry_count == '0))
    else $error("empty status with entries held");

endmodule

bind binary_heap_priority_queue bhpq_check #(
  .DEPTH      (DEPTH),
  .KEY_WIDTH  (KEY_WIDTH),
  .DATA_WIDTH (DATA_WIDTH)
) u_bhpq_check (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_popped_key  (out_popped_key),
  .out_popped_data (out_popped_data),
  .out_top_key     (out_top_key),
  .out_top_data    (out_top_data),
  .out_entry_count (out_entry_count),
  .out_heap_empty  (out_heap_empty)
);
